[src/fprc_pkg.sv]
// Package for the footswitch press and relay control block.
// Holds field widths, configuration register indexes and the control flag record.
// No dependencies.
`timescale 1ns / 1ps

package fprc_pkg;

  // Fixed field widths
  localparam int unsigned INTEG_W   = 16;  // integrator and debounce limit
  localparam int unsigned LPRESS_W  = 25;  // long-press limit register
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 25;

  // Reset values of the configuration registers
  localparam logic [INTEG_W-1:0]  DEBOUNCE_RST   = 16'd100;
  localparam logic [LPRESS_W-1:0] LONG_PRESS_RST = 25'd20000000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 1'b0,
    REG_LONG_PRESS = 1'b1
  } cfg_idx_e;

  // Press tracking and output flags
  typedef struct packed {
    logic effect_on;
    logic feedback_on;
    logic effect_led;
    logic was_released;
    logic toggle_armed;
    logic just_turned_on;
  } flags_t;

  localparam flags_t FLAGS_RST = '{
    effect_on:      1'b0,
    feedback_on:    1'b0,
    effect_led:     1'b0,
    was_released:   1'b1,
    toggle_armed:   1'b0,
    just_turned_on: 1'b0
  };

endpackage

[src/fprc_update.sv]
// Next-state logic for one footswitch tick: debounce integrator, held counter, flags.
// Depends on fprc_pkg.
`timescale 1ns / 1ps

module fprc_update
  import fprc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 25
) (
  input  logic                   level_i,
  input  logic [INTEG_W-1:0]     debounce_i,
  input  logic [LPRESS_W-1:0]    long_press_i,
  input  logic [INTEG_W-1:0]     integ_i,
  input  logic [COUNT_WIDTH-1:0] held_i,
  input  flags_t                 flags_i,
  output logic [INTEG_W-1:0]     integ_o,
  output logic [COUNT_WIDTH-1:0] held_o,
  output flags_t                 flags_o
);

  localparam int unsigned LimW = (COUNT_WIDTH > LPRESS_W) ? COUNT_WIDTH : LPRESS_W;

  logic [LimW-1:0]        lp_ext;
  logic [LimW-1:0]        cmax_ext;
  logic [COUNT_WIDTH-1:0] limit;
  logic [INTEG_W-1:0]     integ_step;
  logic [COUNT_WIDTH-1:0] held_inc;

  // Long-press limit clamped to what the held counter can hold
  assign lp_ext   = LimW'(long_press_i);
  assign cmax_ext = LimW'({COUNT_WIDTH{1'b1}});
  assign limit    = (lp_ext > cmax_ext) ? COUNT_WIDTH'(cmax_ext) : COUNT_WIDTH'(lp_ext);

  // Saturating integrator: down while pressed, up towards the limit while open
  always_comb begin
    integ_step = integ_i;
    if (!level_i) begin
      if (integ_i != '0) integ_step = integ_i - INTEG_W'(1);
    end else if (integ_i < debounce_i) begin
      integ_step = integ_i + INTEG_W'(1);
    end
  end

  // Held counter saturates at the limit
  assign held_inc = (held_i < limit) ? held_i + COUNT_WIDTH'(1) : limit;

  // Held / released decisions
  always_comb begin
    integ_o = integ_step;
    held_o  = held_i;
    flags_o = flags_i;
    if (integ_step == '0) begin
      held_o = held_inc;
      if (flags_i.effect_on) begin
        if (flags_i.was_released) flags_o.toggle_armed = 1'b1;
        if (held_inc >= limit && !flags_i.feedback_on && !flags_i.just_turned_on) begin
          flags_o.effect_led  = 1'b0;
          flags_o.feedback_on = 1'b1;
        end
      end else begin
        flags_o.just_turned_on = 1'b1;
        flags_o.toggle_armed   = 1'b0;
        flags_o.effect_on      = 1'b1;
        flags_o.effect_led     = 1'b1;
        flags_o.feedback_on    = 1'b0;
      end
      flags_o.was_released = 1'b0;
    end else if (integ_step >= debounce_i) begin
      // release: drop feedback, apply an armed toggle, resync the LED
      flags_o.feedback_on    = 1'b0;
      flags_o.effect_on      = flags_i.effect_on & ~flags_i.toggle_armed;
      flags_o.effect_led     = flags_i.effect_on & ~flags_i.toggle_armed;
      flags_o.just_turned_on = 1'b0;
      flags_o.toggle_armed   = 1'b0;
      flags_o.was_released   = 1'b1;
      held_o                 = '0;
      integ_o                = debounce_i;
    end
  end

endmodule

[src/footswitch_press_relay_control.sv]
// Footswitch press and relay control: one input transfer per tick of the raw
// active-low footswitch pin, one result transfer per tick with the LED and relay
// coil levels after that tick's update. The block takes a transfer every cycle
// while in_stall_o is low; each one passes an input register and then a result
// register before out_valid_o rises, and the result is taken in a cycle when
// out_stall_i is low. A stalled result holds the pipeline, and in_stall_o rises
// only once the input register is also full.
// Configuration writes are taken in any cycle.
// Depends on fprc_pkg and fprc_update.
`timescale 1ns / 1ps

module footswitch_press_relay_control
  import fprc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 25
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 switch_level_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 effect_led_o,
  output logic                 effect_relay_on_o,
  output logic                 effect_relay_off_o,
  output logic                 feedback_lamp_o,
  output logic                 feedback_relay_on_o,
  output logic                 feedback_relay_off_o
);

  logic [INTEG_W-1:0]     debounce_q;
  logic [LPRESS_W-1:0]    long_press_q;
  logic                   s1_valid_q;
  logic                   s1_level_q;
  logic [INTEG_W-1:0]     integ_q, integ_d;
  logic [COUNT_WIDTH-1:0] held_q, held_d;
  flags_t                 flags_q, flags_d;
  logic                   out_valid_q;
  logic                   out_eff_q, out_fb_q, out_led_q;
  logic                   advance;
  logic                   in_xfer;
  cfg_idx_e               cfg_idx;

  // Pipeline moves when the result register is empty or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_idx    = cfg_idx_e'(cfg_index_i);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RST;
      long_press_q <= LONG_PRESS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx)
        REG_DEBOUNCE:   debounce_q   <= cfg_data_i[INTEG_W-1:0];
        REG_LONG_PRESS: long_press_q <= cfg_data_i[LPRESS_W-1:0];
        default:        ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance || !s1_valid_q) begin
      s1_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) s1_level_q <= switch_level_i;
  end

  // Tick update
  fprc_update #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_update (
    .level_i      (s1_level_q),
    .debounce_i   (debounce_q),
    .long_press_i (long_press_q),
    .integ_i      (integ_q),
    .held_i       (held_q),
    .flags_i      (flags_q),
    .integ_o      (integ_d),
    .held_o       (held_d),
    .flags_o      (flags_d)
  );

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      held_q      <= '0;
      flags_q     <= FLAGS_RST;
      out_valid_q <= 1'b0;
      out_eff_q   <= 1'b0;
      out_fb_q    <= 1'b0;
      out_led_q   <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        integ_q   <= integ_d;
        held_q    <= held_d;
        flags_q   <= flags_d;
        out_eff_q <= flags_d.effect_on;
        out_fb_q  <= flags_d.feedback_on;
        out_led_q <= flags_d.effect_led;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign effect_led_o         = out_led_q;
  assign effect_relay_on_o    = out_eff_q;
  assign effect_relay_off_o   = ~out_eff_q;
  assign feedback_lamp_o      = out_fb_q;
  assign feedback_relay_on_o  = out_fb_q;
  assign feedback_relay_off_o = ~out_fb_q;

  // Feedback mode only exists with the effect on
  a_fb_needs_effect : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.feedback_on |-> flags_q.effect_on)
    else $error("feedback on with effect off");

  // Feedback mode always has the effect LED dark
  a_fb_led_dark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.feedback_on |-> !flags_q.effect_led)
    else $error("effect LED lit in feedback mode");

  // An armed toggle belongs to a hold with the effect on
  a_toggle_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.toggle_armed |-> (flags_q.effect_on && !flags_q.was_released))
    else $error("toggle armed outside a hold");

  // Just-turned-on marks a hold that switched the effect on
  a_jto_effect : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.just_turned_on |-> (flags_q.effect_on && !flags_q.was_released))
    else $error("just-turned-on flag without effect hold");

  // A full input stage that advances yields a result next cycle
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && advance) |=> out_valid_q)
    else $error("tick lost between input and result register");

endmodule
